@@ rtl/swa_pkg.sv @@
// Shared constants and widths for the sliding window average block.
`default_nettype none
package swa_pkg;

  // Ring and sample geometry
  localparam int WINDOW_MAX   = 1024;
  localparam int PRICE_BITS   = 32;
  localparam int SLOT_W       = $clog2(WINDOW_MAX);
  localparam int WLEN_W       = 11;
  localparam int AVG_W        = 32;
  localparam int SUM_W        = PRICE_BITS + SLOT_W;
  localparam int DIV_CNT_W    = $clog2(SUM_W + 1);

  // Window length after reset
  localparam logic [WLEN_W-1:0] WINDOW_RESET = WLEN_W'(20);
  localparam logic [WLEN_W-1:0] WINDOW_TOP   = WLEN_W'(WINDOW_MAX);

  // Clamp a written window length into 1..WINDOW_MAX
  function automatic logic [WLEN_W-1:0] clamp_window(input logic [WLEN_W-1:0] w);
    logic [WLEN_W-1:0] r;
    r = w;
    if (w == '0) begin
      r = WLEN_W'(1);
    end else if (w > WINDOW_TOP) begin
      r = WINDOW_TOP;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/swa_if.sv @@
// Valid/ready channel interfaces for samples, results and configuration.
`default_nettype none
interface swa_in_if
  import swa_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] price;
  logic                  series_start;
  modport source (output valid, output price, output series_start, input ready);
  modport sink   (input valid, input price, input series_start, output ready);
endinterface

interface swa_out_if
  import swa_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [AVG_W-1:0] average;
  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

interface swa_cfg_if
  import swa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [WLEN_W-1:0] window_length;
  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface
`default_nettype wire

@@ rtl/sliding_window_average_top.sv @@
// Boxcar moving average over a ring of recent price samples.
//
// Channels: samples (price Q24.8, series_start) in, results (average Q24.8)
// out, cfg (window_length) in; all valid/ready, a request moves on an edge
// with valid and ready high. cfg is taken only while the block is idle and
// wins over a sample offered in the same cycle; any write restarts the
// series. Window 0 acts as 1, above 1024 as 1024.
// One request is worked at a time: accept and ring read, update of sum and
// ring write, serial division of the 42-bit sum (42 quotient bits, then the
// done flag), load of the output register. When no result follows, the
// request ends after the ring write. No result is given until a full window
// of samples has arrived since the last restart.
// Reset clears sum, fill count and write slot and sets the window to 20; the
// ring memory is not cleared, as only written entries are ever used.
// A stalled receiver holds the finished quotient in the divider until the
// output register frees up; no new sample is taken meanwhile.
`default_nettype none
module sliding_window_average_top
  import swa_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  swa_in_if.sink   samples,
  swa_out_if.source results,
  swa_cfg_if.sink  cfg
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [WLEN_W-1:0]     win_eff;
  logic [SUM_W-1:0]      running_sum;
  logic [WLEN_W-1:0]     fill_count;
  logic [SLOT_W-1:0]     write_slot;
  logic [PRICE_BITS-1:0] price_q;
  logic [SLOT_W-1:0]     slot_q;
  logic                  full_q;
  logic                  res_valid;
  logic [AVG_W-1:0]      res_data;

  logic                  in_acc;
  logic                  cfg_acc;
  logic                  out_free;
  logic [SLOT_W-1:0]     slot_rd;
  logic [WLEN_W-1:0]     fill_rd;
  logic [PRICE_BITS-1:0] ring_rdata;
  logic [SUM_W-1:0]      sum_new;
  logic [WLEN_W-1:0]     fill_inc;
  logic [WLEN_W-1:0]     slot_inc;
  logic                  emit;
  logic                  div_start;
  logic                  div_done;
  logic [AVG_W-1:0]      div_quo;

  // Handshakes; a pending cfg write holds off samples
  assign samples.ready = (state == ST_IDLE) && !cfg.valid;
  assign cfg.ready     = (state == ST_IDLE);
  assign in_acc        = samples.valid && samples.ready;
  assign cfg_acc       = cfg.valid && cfg.ready;
  assign out_free      = !res_valid || results.ready;

  // Slot and fill seen by the arriving sample
  always_comb begin
    slot_rd = ({1'b0, write_slot} >= win_eff) ? '0 : write_slot;
    fill_rd = fill_count;
    if (samples.series_start) begin
      slot_rd = '0;
      fill_rd = '0;
    end
  end

  // Ring update values, used in ST_READ
  always_comb begin
    sum_new   = running_sum - (full_q ? SUM_W'(ring_rdata) : '0) + SUM_W'(price_q);
    fill_inc  = fill_count + WLEN_W'(1);
    slot_inc  = {1'b0, slot_q} + WLEN_W'(1);
    emit      = full_q || (fill_inc >= win_eff);
    div_start = (state == ST_READ) && emit;
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc) state_next = ST_READ;
      ST_READ: state_next = emit ? ST_DIV : ST_IDLE;
      ST_DIV:  if (div_done) state_next = ST_HOLD;
      ST_HOLD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window, sum, fill count and write slot
  always_ff @(posedge clk) begin
    if (rst) begin
      win_eff     <= WINDOW_RESET;
      running_sum <= '0;
      fill_count  <= '0;
      write_slot  <= '0;
    end else if (cfg_acc) begin
      win_eff     <= clamp_window(cfg.window_length);
      running_sum <= '0;
      fill_count  <= '0;
      write_slot  <= '0;
    end else if (in_acc) begin
      if (samples.series_start) begin
        running_sum <= '0;
        fill_count  <= '0;
      end
    end else if (state == ST_READ) begin
      running_sum <= sum_new;
      if (!full_q) begin
        fill_count <= fill_inc;
      end
      write_slot <= (slot_inc >= win_eff) ? '0 : slot_inc[SLOT_W-1:0];
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      price_q <= samples.price;
      slot_q  <= slot_rd;
      full_q  <= (fill_rd >= win_eff);
    end
  end

  // Sample ring
  swa_ram #(
    .WIDTH (PRICE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_READ),
    .waddr (slot_q),
    .wdata (price_q),
    .re    (in_acc),
    .raddr (slot_rd),
    .rdata (ring_rdata)
  );

  // Serial divider
  swa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_new),
    .divisor  (win_eff),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_HOLD && out_free) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && out_free) begin
      res_data <= div_quo;
    end
  end

  assign results.valid   = res_valid;
  assign results.average = res_data;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= win_eff)
    else $error("fill count exceeds window");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, write_slot} < win_eff)
    else $error("write slot outside window");

  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_READ)
    else $error("accepted sample did not go to ring read");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside divide state");

  a_hold_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD && out_free) |=> res_valid && state == ST_IDLE)
    else $error("finished quotient not loaded into output register");

endmodule
`default_nettype wire

@@ rtl/swa_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none
module swa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/swa_div.sv @@
// Restoring radix-2 divider: window sum over window length, one bit per cycle.
`default_nettype none
module swa_div
  import swa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  dividend,
  input  wire logic [WLEN_W-1:0] divisor,
  output logic                   done,
  output logic      [AVG_W-1:0]  quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SUM_W-1:0]     quo;
  logic [WLEN_W-1:0]    rem;
  logic [WLEN_W-1:0]    dvs;
  logic [WLEN_W:0]      trial;
  logic [WLEN_W:0]      diff;
  logic                 qbit;

  // One trial subtraction per cycle
  always_comb begin
    trial = {rem, quo[SUM_W-1]};
    diff  = trial - {1'b0, dvs};
    qbit  = (trial >= {1'b0, dvs});
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], qbit};
      rem <= qbit ? diff[WLEN_W-1:0] : trial[WLEN_W-1:0];
    end
  end

  assign quotient = quo[AVG_W-1:0];

endmodule
`default_nettype wire
